// ----- sv/wsc_pkg.sv -----
// ----------------------------------------------------------------------------
// wsc_pkg
// Types, constants and helper functions shared by the weather sensor
// compensation modules.
// ----------------------------------------------------------------------------
package wsc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_TEMP_PRESS_LOW = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_MID      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_HIGH     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HUM_FIRST      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HUM_REST       = 3'd4;

  localparam logic [63:0] FINE_P_OFFSET = 64'd128000;
  localparam logic [31:0] FINE_H_OFFSET = 32'd76800;
  localparam logic [63:0] P_FULL_SCALE  = 64'd1048576;
  localparam logic [63:0] P_SCALE       = 64'd3125;
  localparam logic [31:0] H_LIMIT       = 32'd419430400;
  localparam logic [31:0] H_BASE        = 32'd2097152;
  localparam logic [13:0] H_MAX_CENTI   = 14'd10000;

  typedef struct packed {
    logic [19:0] temp;
    logic [19:0] press;
    logic [15:0] hum;
  } raw_t;

  typedef struct packed {
    logic [63:0] low;
    logic [63:0] mid;
    logic [63:0] high;
    logic [7:0]  h1;
    logic [55:0] hrest;
  } cal_t;

  function automatic logic [31:0] asr32(logic [31:0] x, int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int unsigned n);
    return 64'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] sx32(logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic logic [63:0] sx16(logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

endpackage

// ----- sv/wsc_front.sv -----
// ----------------------------------------------------------------------------
// wsc_front
// Two-entry input queue that takes raw readings and holds them until the
// compensation sequencer picks them up.
// ----------------------------------------------------------------------------
module wsc_front import wsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  raw_t item_i,
  output logic valid_o,
  input  logic take_i,
  output raw_t item_o
);

  raw_t        mem [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        do_push, do_take;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = mem[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_take = take_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_take;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- sv/wsc_mul.sv -----
// ----------------------------------------------------------------------------
// wsc_mul
// Multi-cycle multiplier returning the low 64 bits of a product, one 16-bit
// digit of the second operand per cycle.
// ----------------------------------------------------------------------------
module wsc_mul import wsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] prod_o
);

  logic [63:0] a_q, b_q, acc_q;
  logic [1:0]  cnt_q;
  logic        busy_q, done_q;

  assign done_o = done_q;
  assign prod_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + 64'(a_q * {48'd0, b_q[15:0]});
      a_q   <= a_q << 16;
      b_q   <= b_q >> 16;
    end
  end

endmodule

// ----- sv/wsc_div.sv -----
// ----------------------------------------------------------------------------
// wsc_div
// Restoring signed divider, 64-bit, one quotient bit per cycle, truncating
// toward zero.
// ----------------------------------------------------------------------------
module wsc_div import wsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic [64:0] rem_q;
  logic [63:0] quo_q, den_q;
  logic        neg_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [64:0] rem_sh;

  assign rem_sh = {rem_q[63:0], quo_q[63]};
  assign done_o = done_q;
  assign quo_o  = neg_q ? (64'd0 - quo_q) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i[63] ? (64'd0 - num_i) : num_i;
      den_q <= den_i[63] ? (64'd0 - den_i) : den_i;
      neg_q <= num_i[63] ^ den_i[63];
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

endmodule

// ----- sv/wsc_back.sv -----
// ----------------------------------------------------------------------------
// wsc_back
// Compensation sequencer: walks one reading through the temperature,
// pressure and humidity terms on a shared multiplier and divider, and holds
// the finished word in a result register.
// ----------------------------------------------------------------------------
module wsc_back import wsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cal_t        cal_i,
  input  logic        in_valid_i,
  input  raw_t        in_item_i,
  output logic        in_take_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [31:0] temperature_centi_o,
  output logic [23:0] pressure_pascal_o,
  output logic [13:0] humidity_centi_percent_o,
  output logic        divisor_zero_o
);

  localparam logic [4:0] S_IDLE = 5'd0,  S_T0  = 5'd1,  S_T1  = 5'd2,  S_T2  = 5'd3;
  localparam logic [4:0] S_TF   = 5'd4,  S_P0  = 5'd5,  S_P1  = 5'd6,  S_P2  = 5'd7;
  localparam logic [4:0] S_P3   = 5'd8,  S_P4  = 5'd9,  S_P5  = 5'd10, S_P6  = 5'd11;
  localparam logic [4:0] S_P7   = 5'd12, S_P8  = 5'd13, S_P9  = 5'd14, S_P10 = 5'd15;
  localparam logic [4:0] S_H0   = 5'd16, S_H1  = 5'd17, S_H2  = 5'd18, S_H3  = 5'd19;
  localparam logic [4:0] S_H4   = 5'd20, S_H5  = 5'd21, S_H6  = 5'd22, S_H7  = 5'd23;
  localparam logic [4:0] S_DONE = 5'd24;

  logic [4:0]  state_q, state_d;
  logic        issued_q, res_valid_q;
  logic        step_done, mul_state, mul_start, div_start;
  logic [63:0] mul_a, mul_b, mul_p, div_q;
  logic        mul_done, div_done;
  logic [31:0] mp32;

  raw_t        raw_q;
  logic [31:0] v1_q, tmp32_q, fine_q, temp_q;
  logic [63:0] aa_q, c_q, acc_q, a3_q, num_q, p_q, tmp64_q, x1_q;
  logic [31:0] hx_q, hy_q, hz_q, hh_q;
  logic        dz_q;
  logic [23:0] press_q;
  logic [31:0] out_temp_q;
  logic [23:0] out_press_q;
  logic [13:0] out_hum_q;
  logic        out_dz_q;

  // Calibration fields.
  logic [15:0] t1;
  logic [63:0] t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [63:0] h1, h2, h3, h4, h5, h6;

  // Derived operands.
  logic [31:0] d32, e32, hf, s32, h4s;
  logic [63:0] a_w, q_w, pf, pp;
  logic [31:0] hc;
  logic [16:0] hs;
  logic [23:0] hm;
  logic [13:0] hum;

  always_comb begin
    t1 = cal_i.low[15:0];
    t2 = sx16(cal_i.low[31:16]);
    t3 = sx16(cal_i.low[47:32]);
    p1 = {48'd0, cal_i.low[63:48]};
    p2 = sx16(cal_i.mid[15:0]);
    p3 = sx16(cal_i.mid[31:16]);
    p4 = sx16(cal_i.mid[47:32]);
    p5 = sx16(cal_i.mid[63:48]);
    p6 = sx16(cal_i.high[15:0]);
    p7 = sx16(cal_i.high[31:16]);
    p8 = sx16(cal_i.high[47:32]);
    p9 = sx16(cal_i.high[63:48]);
    h1 = {56'd0, cal_i.h1};
    h2 = sx16(cal_i.hrest[15:0]);
    h3 = {56'd0, cal_i.hrest[23:16]};
    h4 = {{52{cal_i.hrest[31]}}, cal_i.hrest[31:24], cal_i.hrest[35:32]};
    h5 = {{52{cal_i.hrest[47]}}, cal_i.hrest[47:40], cal_i.hrest[39:36]};
    h6 = {{56{cal_i.hrest[55]}}, cal_i.hrest[55:48]};
  end

  always_comb begin
    d32 = ({12'd0, raw_q.temp} >> 3) - {15'd0, t1, 1'b0};
    e32 = ({12'd0, raw_q.temp} >> 4) - {16'd0, t1};
    a_w = sx32(fine_q) - FINE_P_OFFSET;
    pp  = P_FULL_SCALE - {44'd0, raw_q.press};
    q_w = asr64(p_q, 13);
    hf  = fine_q - FINE_H_OFFSET;
    s32 = asr32(hh_q, 15);
    h4s = h4[31:0] << 20;
    mp32 = mul_p[31:0];
    pf  = asr64(p_q + x1_q + asr64(mul_p, 19), 8) + (p7 << 4);
    hc  = hh_q[31] ? 32'd0 : ((hh_q > H_LIMIT) ? H_LIMIT : hh_q);
    hs  = hc[28:12];
    hm  = 24'({7'd0, hs} * 24'd100) >> 10;
    hum = (hm > {10'd0, H_MAX_CENTI}) ? H_MAX_CENTI : hm[13:0];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_T0:  begin mul_a = sx32(d32);     mul_b = t2; end
      S_T1:  begin mul_a = sx32(e32);     mul_b = sx32(e32); end
      S_T2:  begin mul_a = sx32(tmp32_q); mul_b = t3; end
      S_P0:  begin mul_a = a_w;           mul_b = a_w; end
      S_P1:  begin mul_a = aa_q;          mul_b = p6; end
      S_P2:  begin mul_a = a_w;           mul_b = p5; end
      S_P3:  begin mul_a = aa_q;          mul_b = p3; end
      S_P4:  begin mul_a = a_w;           mul_b = p2; end
      S_P5:  begin mul_a = (64'd1 << 47) + acc_q; mul_b = p1; end
      S_P6:  begin mul_a = (pp << 31) - c_q; mul_b = P_SCALE; end
      S_P8:  begin mul_a = p9;            mul_b = q_w; end
      S_P9:  begin mul_a = tmp64_q;       mul_b = q_w; end
      S_P10: begin mul_a = p8;            mul_b = p_q; end
      S_H0:  begin mul_a = h5;            mul_b = sx32(hf); end
      S_H1:  begin mul_a = sx32(hf);      mul_b = h6; end
      S_H2:  begin mul_a = sx32(hf);      mul_b = h3; end
      S_H3:  begin mul_a = sx32(hy_q);    mul_b = sx32(hz_q); end
      S_H4:  begin mul_a = sx32(hy_q);    mul_b = h2; end
      S_H5:  begin mul_a = sx32(hx_q);    mul_b = sx32(hy_q); end
      S_H6:  begin mul_a = sx32(s32);     mul_b = sx32(s32); end
      S_H7:  begin mul_a = sx32(tmp32_q); mul_b = h1; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    mul_state = 1'b0;
    step_done = 1'b0;
    case (state_q)
      S_IDLE: step_done = in_valid_i;
      S_TF:   step_done = 1'b1;
      S_P6: begin
        mul_state = (a3_q != 64'd0);
        step_done = (a3_q == 64'd0) || (issued_q && mul_done);
      end
      S_P7:   step_done = issued_q && div_done;
      S_DONE: step_done = !res_valid_q || pop_i;
      default: begin
        mul_state = 1'b1;
        step_done = issued_q && mul_done;
      end
    endcase
    mul_start = mul_state && !issued_q;
    div_start = (state_q == S_P7) && !issued_q;
    in_take_o = (state_q == S_IDLE) && in_valid_i;
  end

  always_comb begin
    state_d = state_q;
    if (step_done) begin
      case (state_q)
        S_P6:    state_d = (a3_q == 64'd0) ? S_H0 : S_P7;
        S_DONE:  state_d = S_IDLE;
        default: state_d = state_q + 5'd1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (step_done) begin
        issued_q <= 1'b0;
      end else if (mul_start || div_start) begin
        issued_q <= 1'b1;
      end
      if (state_q == S_DONE && step_done) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_done) begin
      case (state_q)
        S_IDLE: raw_q   <= in_item_i;
        S_T0:   v1_q    <= asr32(mp32, 11);
        S_T1:   tmp32_q <= asr32(mp32, 12);
        S_T2:   fine_q  <= v1_q + asr32(mp32, 14);
        S_TF:   temp_q  <= asr32(fine_q + (fine_q << 2) + 32'd128, 8);
        S_P0:   aa_q    <= mul_p;
        S_P1:   c_q     <= mul_p;
        S_P2:   c_q     <= c_q + (mul_p << 17) + (p4 << 35);
        S_P3:   acc_q   <= asr64(mul_p, 8);
        S_P4:   acc_q   <= acc_q + (mul_p << 12);
        S_P5:   a3_q    <= asr64(mul_p, 33);
        S_P6: begin
          dz_q  <= (a3_q == 64'd0);
          num_q <= mul_p;
          if (a3_q == 64'd0) begin
            press_q <= '0;
          end
        end
        S_P7:   p_q     <= div_q;
        S_P8:   tmp64_q <= mul_p;
        S_P9:   x1_q    <= asr64(mul_p, 25);
        S_P10: begin
          if (pf[63]) begin
            press_q <= '0;
          end else if (pf[62:32] != 31'd0) begin
            press_q <= '1;
          end else begin
            press_q <= pf[31:8];
          end
        end
        S_H0: hx_q <= asr32(({16'd0, raw_q.hum} << 14) - h4s - mp32 + 32'd16384, 15);
        S_H1: hy_q <= asr32(mp32, 10);
        S_H2: hz_q <= asr32(mp32, 11) + 32'd32768;
        S_H3: hy_q <= asr32(mp32, 10) + H_BASE;
        S_H4: hy_q <= asr32(mp32 + 32'd8192, 14);
        S_H5: hh_q <= mp32;
        S_H6: tmp32_q <= asr32(mp32, 7);
        S_H7: hh_q <= hh_q - asr32(mp32, 4);
        S_DONE: begin
          out_temp_q  <= temp_q;
          out_press_q <= press_q;
          out_hum_q   <= hum;
          out_dz_q    <= dz_q;
        end
        default: ;
      endcase
    end
  end

  wsc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  wsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (a3_q),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  assign empty_o                  = !res_valid_q;
  assign temperature_centi_o      = out_temp_q;
  assign pressure_pascal_o        = out_press_q;
  assign humidity_centi_percent_o = out_hum_q;
  assign divisor_zero_o           = out_dz_q;

endmodule

// ----- sv/weather_sensor_compensation.sv -----
// ----------------------------------------------------------------------------
// weather_sensor_compensation
// Integer compensation of raw temperature, pressure and humidity readings
// against calibration words held in local registers.
//
//   Channel   Handshake               Word
//   input     push_i / full_o         raw temperature, pressure, humidity
//   result    empty_o / pop_i         temperature, pressure, humidity, flag
//   config    cfg_valid_i/cfg_ready_o register index and 64-bit data
//
// A reading needs twenty-one products on the shared 64x16-per-cycle
// multiplier and one pass through the bit-serial divider; a zero divisor
// skips the divider and four products.
// Two readings can wait in the input queue while one is worked on, and the
// next reading starts while the previous result waits to be popped.
// Reset clears all calibration registers and leaves both queues empty.
// ----------------------------------------------------------------------------
module weather_sensor_compensation import wsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [19:0]        raw_temperature_i,
  input  logic [19:0]        raw_pressure_i,
  input  logic [15:0]        raw_humidity_i,
  output logic               empty_o,
  input  logic               pop_i,
  output logic signed [31:0] temperature_centi_o,
  output logic [23:0]        pressure_pascal_o,
  output logic [13:0]        humidity_centi_percent_o,
  output logic               divisor_zero_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  cal_t        cal_q;
  raw_t        in_item, fr_item;
  logic        fr_valid, fr_take;
  logic [31:0] temp_w;

  assign cfg_ready_o = 1'b1;
  assign in_item     = '{temp: raw_temperature_i, press: raw_pressure_i,
                         hum: raw_humidity_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TEMP_PRESS_LOW: cal_q.low   <= cfg_data_i;
        CFG_PRESS_MID:      cal_q.mid   <= cfg_data_i;
        CFG_PRESS_HIGH:     cal_q.high  <= cfg_data_i;
        CFG_HUM_FIRST:      cal_q.h1    <= cfg_data_i[7:0];
        CFG_HUM_REST:       cal_q.hrest <= cfg_data_i[55:0];
        default: ;
      endcase
    end
  end

  wsc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .full_o  (full_o),
    .item_i  (in_item),
    .valid_o (fr_valid),
    .take_i  (fr_take),
    .item_o  (fr_item)
  );

  wsc_back u_back (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cal_i                    (cal_q),
    .in_valid_i               (fr_valid),
    .in_item_i                (fr_item),
    .in_take_o                (fr_take),
    .pop_i                    (pop_i),
    .empty_o                  (empty_o),
    .temperature_centi_o      (temp_w),
    .pressure_pascal_o        (pressure_pascal_o),
    .humidity_centi_percent_o (humidity_centi_percent_o),
    .divisor_zero_o           (divisor_zero_o)
  );

  assign temperature_centi_o = $signed(temp_w);

endmodule
